>>> sv/flma_pkg.sv
// Package for the flow loss and metric aggregator: shared constants, types.
// No dependencies.
`default_nettype none
package flma_pkg;
  localparam int TABLE_SLOTS_DEF  = 256;
  localparam int METRIC_KINDS_DEF = 4;
  localparam logic [7:0] MIN_PACKET_LEN = 8'd21;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_SHORT    = 2'd1;
  localparam logic [1:0] ST_BAD_KIND = 2'd2;
  localparam logic [1:0] ST_FULL     = 2'd3;

  // classified item handed from front to back
  typedef struct packed {
    logic [1:0]         status;
    logic [31:0]        flow_id;
    logic [31:0]        seq_num;
    logic [7:0]         metric_kind;
    logic signed [31:0] sample_value;
  } flma_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [7:0]         slot_index;
    logic [31:0]        lost_now;
    logic [31:0]        client_received;
    logic [31:0]        client_lost;
    logic [31:0]        kind_count;
    logic signed [63:0] kind_sum;
    logic signed [31:0] kind_min;
    logic signed [31:0] kind_max;
    logic [31:0]        total_received;
    logic [31:0]        total_lost;
  } flma_result_t;
endpackage
`default_nettype wire

>>> sv/flma_front.sv
// Front end: accepts items, runs the length and kind checks.
// Depends on flma_pkg.
`default_nettype none
module flma_front #(
  parameter int METRIC_KINDS = flma_pkg::METRIC_KINDS_DEF
) (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire                     in_valid,
  output logic                    in_ready,
  input  wire  [7:0]              in_packet_length,
  input  wire  [31:0]             in_flow_id,
  input  wire  [31:0]             in_seq_num,
  input  wire  [7:0]              in_metric_kind,
  input  wire  signed [31:0]      in_sample_value,
  output logic                    q_valid,
  input  wire                     q_ready,
  output flma_pkg::flma_item_t    q_item
);
  import flma_pkg::*;

  flma_item_t item_r, item_nxt;
  logic       valid_r;

  assign in_ready = !valid_r || q_ready;
  assign q_valid  = valid_r;
  assign q_item   = item_r;

  always_comb begin
    item_nxt.flow_id      = in_flow_id;
    item_nxt.seq_num      = in_seq_num;
    item_nxt.metric_kind  = in_metric_kind;
    item_nxt.sample_value = in_sample_value;
    if (in_packet_length < MIN_PACKET_LEN) begin
      item_nxt.status = ST_SHORT;
    end else if ({24'd0, in_metric_kind} >= 32'(METRIC_KINDS)) begin
      item_nxt.status = ST_BAD_KIND;
    end else begin
      item_nxt.status = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
    if (in_valid && in_ready) begin
      item_r <= item_nxt;
    end
  end
endmodule
`default_nettype wire

>>> sv/flma_queue.sv
// Two-entry FIFO between front and back.
// Depends on flma_pkg.
`default_nettype none
module flma_queue (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   wr_valid,
  output logic                  wr_ready,
  input  flma_pkg::flma_item_t  wr_item,
  output logic                  rd_valid,
  input  wire                   rd_ready,
  output flma_pkg::flma_item_t  rd_item
);
  import flma_pkg::*;

  flma_item_t mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       wr_en, rd_en;

  assign wr_ready = cnt_r != 2'd2;
  assign rd_valid = cnt_r != 2'd0;
  assign rd_item  = mem_r[rp_r];
  assign wr_en    = wr_valid && wr_ready;
  assign rd_en    = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (wr_en) wp_r <= !wp_r;
      if (rd_en) rp_r <= !rp_r;
      cnt_r <= cnt_r + {1'b0, wr_en} - {1'b0, rd_en};
    end
    if (wr_en) begin
      mem_r[wp_r] <= wr_item;
    end
  end
endmodule
`default_nettype wire

>>> sv/flma_back.sv
// Back end: probes the client table, updates client and metric records.
// Depends on flma_pkg. Holds the slot and record memories.
`default_nettype none
module flma_back #(
  parameter int METRIC_KINDS = flma_pkg::METRIC_KINDS_DEF
) (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    q_valid,
  output logic                   q_ready,
  input  flma_pkg::flma_item_t   q_item,
  output logic                   res_valid,
  input  wire                    res_ready,
  output flma_pkg::flma_result_t res,
  output logic                   busy
);
  import flma_pkg::*;

  localparam int TABLE_SLOTS = TABLE_SLOTS_DEF;
  localparam int SW = $clog2(TABLE_SLOTS);
  localparam int KW = (METRIC_KINDS > 1) ? $clog2(METRIC_KINDS) : 1;
  localparam int RW = SW + KW;
  // metric rows are addressed {slot, kind}
  localparam int ROWS = TABLE_SLOTS << KW;
  localparam logic [SW:0] SLOTS_W = (SW + 1)'(TABLE_SLOTS);
  localparam logic [RW:0] ROWS_W  = (RW + 1)'(ROWS);

  typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_PROBE, S_CHECK, S_UPDATE, S_OUT}
    state_t;

  // slot record (no epoch field): used, key, expected seq, received, lost
  typedef struct packed {
    logic        used;
    logic [31:0] key;
    logic [31:0] nseq;
    logic [31:0] rcv;
    logic [31:0] lost;
  } slot_t;

  typedef struct packed {
    logic [31:0]        cnt;
    logic signed [63:0] sum;
    logic signed [31:0] mn;
    logic signed [31:0] mx;
  } mrec_t;

  localparam mrec_t MREC_INIT = '{32'd0, 64'sd0, 32'sh7FFFFFFF, 32'sh80000000};

  slot_t slot_mem [TABLE_SLOTS];
  mrec_t met_mem  [ROWS];

  state_t       state_r;
  flma_item_t   item_r;
  logic [RW:0]  clr_r;
  logic [SW-1:0] slot_r;
  logic [SW:0]  tries_r;
  slot_t        srd_r;
  mrec_t        mrd_r;
  logic         fresh_r;
  logic [31:0]  grcv_r, glost_r;
  flma_result_t res_r;
  logic         res_v_r;
  logic         res_load;

  logic [RW-1:0] row;
  logic [KW-1:0] kidx;
  slot_t         s_new;
  mrec_t         m_old, m_new;
  logic [31:0]   lost_v;
  logic signed [64:0] sum_w;

  assign kidx = item_r.metric_kind[KW-1:0];
  assign row  = (RW)'({slot_r, kidx} >> 0);

  always_comb begin
    m_old = fresh_r ? MREC_INIT : mrd_r;
    s_new = srd_r;
    if (fresh_r) begin
      s_new = slot_t'{1'b1, item_r.flow_id, 32'd0, 32'd0, 32'd0};
    end
    lost_v = 32'd0;
    if (s_new.rcv != 32'd0 && item_r.seq_num > s_new.nseq) begin
      lost_v = item_r.seq_num - s_new.nseq;
    end
    s_new.lost = s_new.lost + lost_v;
    s_new.nseq = item_r.seq_num + 32'd1;
    s_new.rcv  = s_new.rcv + 32'd1;
    m_new.cnt  = m_old.cnt + 32'd1;
    sum_w      = {m_old.sum[63], m_old.sum} + 65'(item_r.sample_value);
    if (sum_w[64] != sum_w[63]) begin
      m_new.sum = sum_w[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    end else begin
      m_new.sum = sum_w[63:0];
    end
    m_new.mn = (item_r.sample_value < m_old.mn) ? item_r.sample_value : m_old.mn;
    m_new.mx = (item_r.sample_value > m_old.mx) ? item_r.sample_value : m_old.mx;
  end

  assign q_ready   = state_r == S_IDLE;
  assign res_valid = res_v_r;
  assign res       = res_r;
  assign busy      = state_r != S_IDLE || res_v_r;
  assign res_load  = (state_r == S_UPDATE || state_r == S_OUT) && (!res_v_r || res_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r   <= '0;
      grcv_r  <= 32'd0;
      glost_r <= 32'd0;
      res_v_r <= 1'b0;
    end else begin
      if (res_load) begin
        res_v_r <= 1'b1;
      end else if (res_ready) begin
        res_v_r <= 1'b0;
      end
      case (state_r)
        S_CLEAR: begin
          slot_mem[clr_r[RW-1:KW]] <= '0;
          met_mem[clr_r[RW-1:0]]   <= MREC_INIT;
          clr_r <= clr_r + 1'b1;
          if (clr_r == ROWS_W - 1'b1) state_r <= S_IDLE;
        end
        S_IDLE: begin
          if (q_valid) begin
            item_r  <= q_item;
            slot_r  <= q_item.flow_id[SW-1:0];
            tries_r <= '0;
            state_r <= (q_item.status == ST_OK) ? S_PROBE : S_OUT;
          end
        end
        S_PROBE: begin
          srd_r   <= slot_mem[slot_r];
          state_r <= S_CHECK;
        end
        S_CHECK: begin
          // hit or free slot: fetch the metric row in the same cycle
          if (!srd_r.used || srd_r.key == item_r.flow_id) begin
            fresh_r <= !srd_r.used;
            mrd_r   <= met_mem[row];
            state_r <= S_UPDATE;
          end else if (tries_r == SLOTS_W - 1'b1) begin
            item_r.status <= ST_FULL;
            state_r <= S_OUT;
          end else begin
            tries_r <= tries_r + 1'b1;
            slot_r  <= slot_r + 1'b1;
            state_r <= S_PROBE;
          end
        end
        S_UPDATE: begin
          if (res_load) begin
            slot_mem[slot_r] <= s_new;
            met_mem[row]     <= m_new;
            grcv_r  <= grcv_r + 32'd1;
            glost_r <= glost_r + lost_v;
            res_r <= flma_result_t'{ST_OK, 8'(slot_r), lost_v, s_new.rcv, s_new.lost,
              m_new.cnt, m_new.sum, m_new.mn, m_new.mx, grcv_r + 32'd1, glost_r + lost_v};
            state_r <= S_IDLE;
          end
        end
        S_OUT: begin
          if (res_load) begin
            res_r <= flma_result_t'{item_r.status, 8'd0, 32'd0, 32'd0, 32'd0, 32'd0,
              64'sd0, 32'sd0, 32'sd0, grcv_r, glost_r};
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

>>> sv/flow_loss_and_metric_aggregator.sv
// Top level of the flow loss and metric aggregator.
// Depends on flma_pkg, flma_front, flma_queue, flma_back.
//
//  port group | direction | contents
//  in_*       | input     | packet fields, valid/ready (in_ready is an output)
//  out_*      | output    | status, client and kind records, totals (out_ready is an input)
//
// A hitting item passes the back end through accept, slot read, compare
// with metric read, and update into the result register, which raises
// out_valid. Each extra probe repeats slot read and compare; a full table
// is probed in every slot. Dropped items pass accept and the output step.
// After reset the tables are cleared over TABLE_SLOTS*2^clog2(METRIC_KINDS)
// metric rows (1024 by default); front and queue take up to 3 items meanwhile.
// A stalled out_ready holds the result register and the back end.
`default_nettype none
module flow_loss_and_metric_aggregator #(
  parameter int METRIC_KINDS = flma_pkg::METRIC_KINDS_DEF
) (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                in_valid,
  output logic               in_ready,
  input  wire  [7:0]         in_packet_length,
  input  wire  [31:0]        in_flow_id,
  input  wire  [31:0]        in_seq_num,
  input  wire  [7:0]         in_metric_kind,
  input  wire  signed [31:0] in_sample_value,
  output logic               out_valid,
  input  wire                out_ready,
  output logic [1:0]         out_status,
  output logic [7:0]         out_slot_index,
  output logic [31:0]        out_lost_now,
  output logic [31:0]        out_client_received,
  output logic [31:0]        out_client_lost,
  output logic [31:0]        out_kind_count,
  output logic signed [63:0] out_kind_sum,
  output logic signed [31:0] out_kind_min,
  output logic signed [31:0] out_kind_max,
  output logic [31:0]        out_total_received,
  output logic [31:0]        out_total_lost
);
  import flma_pkg::*;

  flma_item_t   f_item, b_item;
  logic         f_valid, f_ready, b_valid, b_ready, busy;
  flma_result_t res;

  flma_front #(.METRIC_KINDS(METRIC_KINDS)) u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_packet_length, .in_flow_id,
    .in_seq_num, .in_metric_kind, .in_sample_value,
    .q_valid(f_valid), .q_ready(f_ready), .q_item(f_item));

  flma_queue u_queue (
    .clk, .rst_n, .wr_valid(f_valid), .wr_ready(f_ready), .wr_item(f_item),
    .rd_valid(b_valid), .rd_ready(b_ready), .rd_item(b_item));

  flma_back #(.METRIC_KINDS(METRIC_KINDS)) u_back (
    .clk, .rst_n, .q_valid(b_valid), .q_ready(b_ready), .q_item(b_item),
    .res_valid(out_valid), .res_ready(out_ready), .res(res), .busy(busy));

  assign out_status          = res.status;
  assign out_slot_index      = res.slot_index;
  assign out_lost_now        = res.lost_now;
  assign out_client_received = res.client_received;
  assign out_client_lost     = res.client_lost;
  assign out_kind_count      = res.kind_count;
  assign out_kind_sum        = res.kind_sum;
  assign out_kind_min        = res.kind_min;
  assign out_kind_max        = res.kind_max;
  assign out_total_received  = res.total_received;
  assign out_total_lost      = res.total_lost;

  a_drop_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_client_received == 32'd0)
    else $error("dropped item carries client data");
  a_ok_rcv: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_OK |-> out_client_received != 32'd0 ||
      out_total_received == 32'd0)
    else $error("accepted item with zero received count");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy)
    else $error("result shown while back end idle");
endmodule
`default_nettype wire
